/* hdl/bbp_pkg.sv */
// Shared constants, register codes and the job record of the binomial blur pass.
`timescale 1ns / 1ps
`default_nettype none

package bbp_pkg;

  localparam int SAMPLE_W       = 8;
  localparam int SUM_W          = SAMPLE_W + 2;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int OUT_POS_W      = 10;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int JOB_FIFO_DEPTH = 4;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // One column job: a horizontal result plus what the vertical pass needs to know.
  typedef struct packed {
    logic                emit;         // row above exists, so results are produced
    logic                last_row;     // job belongs to the bottom row
    logic                row_one;      // vertical top neighbor is missing
    logic                pair_first;   // first of the two jobs of a last-column item
    logic                pair_second;  // second of the two jobs of a last-column item
    logic                last_job;     // final job of its item
    logic                frame_end;    // job of the bottom-right pixel
    logic [SAMPLE_W-1:0] hv;           // horizontal blur value
  } job_info_t;

endpackage

`default_nettype wire

/* hdl/bbp_job_fifo.sv */
// Small register FIFO that carries column jobs from the front to the back.
`timescale 1ns / 1ps
`default_nettype none

module bbp_job_fifo
  import bbp_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic      [DATA_W-1:0] head_data,
  output logic                   full,
  output logic                   empty
);

  localparam int PW = $clog2(JOB_FIFO_DEPTH);
  localparam int NW = $clog2(JOB_FIFO_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [JOB_FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [NW-1:0]     count_r;

  assign full      = (count_r == NW'(JOB_FIFO_DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/bbp_front.sv */
// Front part: configuration, input acceptance, horizontal pass and job generation.
`timescale 1ns / 1ps
`default_nettype none

module bbp_front
  import bbp_pkg::*;
#(
  parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW         = $clog2(MAX_WIDTH),
  localparam int RW         = $clog2(MAX_HEIGHT)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  input  wire logic                 fifo_full,
  output logic                      push,
  output job_info_t                 push_info,
  output logic      [CW-1:0]        push_col,
  output logic      [RW-1:0]        push_row
);

  localparam int DW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int DH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CFG_W-1:0]    frame_width_r;
  logic [CFG_W-1:0]    frame_height_r;
  logic [SAMPLE_W-1:0] p1_r;
  logic [SAMPLE_W-1:0] p2_r;
  logic [CW-1:0]       col_r;
  logic [RW-1:0]       row_r;
  logic                pend_valid_r;
  job_info_t           pend_info_r;
  logic [CW-1:0]       pend_col_r;
  logic [RW-1:0]       pend_row_r;

  logic [DW-1:0]    w_ext, w_eff;
  logic [DH-1:0]    h_ext, h_eff;
  logic [CW-1:0]    w_last;
  logic [RW-1:0]    h_last;
  logic             last_col, last_row, accept;
  logic [SUM_W-1:0] sum_a, sum_b;
  job_info_t        info_a, info_b;

  // Out-of-range dimensions are clamped to the supported span.
  always_comb begin
    w_ext = DW'(frame_width_r);
    h_ext = DH'(frame_height_r);
    if (w_ext < DW'(2)) begin
      w_eff = DW'(2);
    end else if (w_ext > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < DH'(2)) begin
      h_eff = DH'(2);
    end else if (h_ext > DH'(MAX_HEIGHT)) begin
      h_eff = DH'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    w_last = CW'(w_eff - DW'(1));
    h_last = RW'(h_eff - DH'(1));
  end

  assign last_col = (col_r == w_last);
  assign last_row = (row_r == h_last);
  assign in_ready = !pend_valid_r && !fifo_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (col_r == CW'(1)) begin
      sum_a = {1'b0, p1_r, 1'b0} + SUM_W'(in_sample);
    end else begin
      sum_a = SUM_W'(p2_r) + {1'b0, p1_r, 1'b0} + SUM_W'(in_sample);
    end
    sum_b = SUM_W'(p1_r) + {1'b0, in_sample, 1'b0};

    info_a.emit        = (row_r != '0);
    info_a.last_row    = last_row;
    info_a.row_one     = (row_r == RW'(1));
    info_a.pair_first  = last_col;
    info_a.pair_second = 1'b0;
    info_a.last_job    = !last_col;
    info_a.frame_end   = 1'b0;
    info_a.hv          = sum_a[SUM_W-1:2];

    info_b             = info_a;
    info_b.pair_first  = 1'b0;
    info_b.pair_second = 1'b1;
    info_b.last_job    = 1'b1;
    info_b.frame_end   = last_row;
    info_b.hv          = sum_b[SUM_W-1:2];
  end

  // The second job of a last-column item waits in the pending slot until the queue has room.
  always_comb begin
    if (pend_valid_r) begin
      push      = !fifo_full;
      push_info = pend_info_r;
      push_col  = pend_col_r;
      push_row  = pend_row_r;
    end else begin
      push      = accept && (col_r != '0);
      push_info = info_a;
      push_col  = CW'(col_r - CW'(1));
      push_row  = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_DIM_RESET;
      frame_height_r <= CFG_DIM_RESET;
      p1_r           <= '0;
      p2_r           <= '0;
      col_r          <= '0;
      row_r          <= '0;
      pend_valid_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_data;
          col_r         <= '0;
          row_r         <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_data;
          col_r          <= '0;
          row_r          <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      if (pend_valid_r && !fifo_full) begin
        pend_valid_r <= 1'b0;
      end
      if (accept) begin
        p2_r <= p1_r;
        p1_r <= in_sample;
        if (last_col) begin
          pend_valid_r <= 1'b1;
          col_r        <= '0;
          row_r        <= last_row ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_info_r <= info_b;
      pend_col_r  <= col_r;
      pend_row_r  <= row_r;
    end
  end

endmodule

`default_nettype wire

/* hdl/bbp_back.sv */
// Back part: line stores, vertical pass, result ordering and output register.
`timescale 1ns / 1ps
`default_nettype none

module bbp_back
  import bbp_pkg::*;
#(
  parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW         = $clog2(MAX_WIDTH),
  localparam int RW         = $clog2(MAX_HEIGHT)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fifo_empty,
  output logic                      fifo_pop,
  input  wire job_info_t            head_info,
  input  wire logic [CW-1:0]        head_col,
  input  wire logic [RW-1:0]        head_row,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [SAMPLE_W-1:0]  out_blurred,
  output logic      [OUT_POS_W-1:0] out_col,
  output logic      [OUT_POS_W-1:0] out_row,
  output logic                      out_run_last,
  output logic                      out_frame_done
);

  typedef enum logic [1:0] {
    PH_UPPER,
    PH_HELD,
    PH_LOWER
  } phase_t;

  logic [SAMPLE_W-1:0] line_older_r [MAX_WIDTH];
  logic [SAMPLE_W-1:0] line_newer_r [MAX_WIDTH];

  logic                s1_valid_r;
  job_info_t           s1_info_r;
  logic [CW-1:0]       s1_col_r;
  logic [RW-1:0]       s1_row_r;
  logic [SAMPLE_W-1:0] top_r;
  logic [SAMPLE_W-1:0] mid_r;
  phase_t              phase_r;
  logic [SAMPLE_W-1:0] hold_val_r;
  logic [CW-1:0]       hold_col_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_blurred_r;
  logic [CW-1:0]       out_col_r;
  logic [RW-1:0]       out_row_r;
  logic                out_run_last_r;
  logic                out_frame_done_r;

  logic [SUM_W-1:0]    upper_sum, lower_sum;
  logic [SAMPLE_W-1:0] upper_val, lower_val;
  logic                out_free, load, depart, hold_we;
  phase_t              phase_nxt;
  logic [SAMPLE_W-1:0] res_val;
  logic [CW-1:0]       res_col;
  logic [RW-1:0]       res_row;
  logic                res_last, res_done;

  always_comb begin
    if (s1_info_r.row_one) begin
      upper_sum = {1'b0, mid_r, 1'b0} + SUM_W'(s1_info_r.hv);
    end else begin
      upper_sum = SUM_W'(top_r) + {1'b0, mid_r, 1'b0} + SUM_W'(s1_info_r.hv);
    end
    lower_sum = SUM_W'(mid_r) + {1'b0, s1_info_r.hv, 1'b0};
    upper_val = upper_sum[SUM_W-1:2];
    lower_val = lower_sum[SUM_W-1:2];
  end

  assign out_free = !out_valid_r || out_ready;

  // Results of one item go out uppers first, then lowers; on the bottom row the
  // first job of a last-column pair parks its lower result until the second
  // job's upper result is out.
  always_comb begin
    depart    = 1'b0;
    load      = 1'b0;
    hold_we   = 1'b0;
    phase_nxt = phase_r;
    res_val   = upper_val;
    res_col   = s1_col_r;
    res_row   = RW'(s1_row_r - RW'(1));
    res_last  = 1'b0;
    res_done  = 1'b0;
    if (s1_valid_r) begin
      if (!s1_info_r.emit) begin
        depart = 1'b1;
      end else if (out_free) begin
        load = 1'b1;
        case (phase_r)
          PH_UPPER: begin
            res_last = s1_info_r.last_job && !s1_info_r.last_row;
            if (s1_info_r.last_row && s1_info_r.pair_second) begin
              phase_nxt = PH_HELD;
            end else if (s1_info_r.last_row && !s1_info_r.pair_first) begin
              phase_nxt = PH_LOWER;
            end else begin
              depart = 1'b1;
            end
            hold_we = s1_info_r.last_row && s1_info_r.pair_first;
          end
          PH_HELD: begin
            res_val   = hold_val_r;
            res_col   = hold_col_r;
            res_row   = s1_row_r;
            phase_nxt = PH_LOWER;
          end
          PH_LOWER: begin
            res_val   = lower_val;
            res_row   = s1_row_r;
            res_last  = s1_info_r.last_job;
            res_done  = s1_info_r.frame_end;
            depart    = 1'b1;
            phase_nxt = PH_UPPER;
          end
          default: begin
            load      = 1'b0;
            phase_nxt = PH_UPPER;
          end
        endcase
      end
    end
  end

  assign fifo_pop = !fifo_empty && (!s1_valid_r || depart);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_UPPER;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (fifo_pop) begin
        s1_valid_r <= 1'b1;
      end else if (depart) begin
        s1_valid_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      s1_info_r <= head_info;
      s1_col_r  <= head_col;
      s1_row_r  <= head_row;
    end
    if (hold_we) begin
      hold_val_r <= lower_val;
      hold_col_r <= s1_col_r;
    end
    if (load) begin
      out_blurred_r    <= res_val;
      out_col_r        <= res_col;
      out_row_r        <= res_row;
      out_run_last_r   <= res_last;
      out_frame_done_r <= res_done;
    end
  end

  // Line stores: read when a job enters, written back when it leaves.
  always_ff @(posedge clk) begin
    if (depart) begin
      line_older_r[s1_col_r] <= mid_r;
      line_newer_r[s1_col_r] <= s1_info_r.hv;
    end
    if (fifo_pop) begin
      top_r <= line_older_r[head_col];
      mid_r <= line_newer_r[head_col];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blurred    = out_blurred_r;
  assign out_col        = OUT_POS_W'(out_col_r);
  assign out_row        = OUT_POS_W'(out_row_r);
  assign out_run_last   = out_run_last_r;
  assign out_frame_done = out_frame_done_r;

endmodule

`default_nettype wire

/* hdl/binomial_blur_pass_core.sv */
// Top level of the separable 3x3 binomial blur pass: front, job queue and back.
// An item's column jobs pass through the job queue and the job stage register before
// their results are loaded into the output register.
// Throughput: one item per cycle inside a row while the queue has room; the last
// item of a row makes two column jobs, so input waits while its second job is pending;
// on the bottom row the single output port limits the rate to one result per cycle.
// Reset (rst_n, synchronous, active low): width and height return to 2, position
// counters and handshakes clear; the line stores keep their contents.
`timescale 1ns / 1ps
`default_nettype none

module binomial_blur_pass_core
  import bbp_pkg::*;
#(
  parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [SAMPLE_W-1:0]  out_blurred,
  output logic      [OUT_POS_W-1:0] out_col,
  output logic      [OUT_POS_W-1:0] out_row,
  output logic                      out_run_last,
  output logic                      out_frame_done
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int INFO_W = $bits(job_info_t);
  localparam int JOB_W  = INFO_W + CW + RW;

  // The front turns each accepted item into zero, one or two column jobs: the
  // column behind the current one is finished once its right neighbor arrives,
  // and the last column of a row is finished at once with its border rule.
  logic            push, pop, fifo_full, fifo_empty;
  job_info_t       push_info, head_info;
  logic [CW-1:0]   push_col, head_col;
  logic [RW-1:0]   push_row, head_row;
  logic [JOB_W-1:0] push_job, head_job;

  bbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .fifo_full (fifo_full),
    .push      (push),
    .push_info (push_info),
    .push_col  (push_col),
    .push_row  (push_row)
  );

  // The queue lets the front keep taking items while the back waits on the
  // output port, and lets the back drain while the input side idles.
  assign push_job = {push_info, push_col, push_row};

  bbp_job_fifo #(
    .DATA_W (JOB_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head_data (head_job),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  assign head_info = head_job[JOB_W-1 -: INFO_W];
  assign head_col  = head_job[CW+RW-1 -: CW];
  assign head_row  = head_job[RW-1:0];

  // The back reads both line stores for the job's column, applies the vertical
  // kernel, writes the column history back and issues the results in order.
  bbp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_empty     (fifo_empty),
    .fifo_pop       (pop),
    .head_info      (head_info),
    .head_col       (head_col),
    .head_row       (head_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blurred    (out_blurred),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

endmodule

`default_nettype wire
